// File: hdl/twhg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twhg_pkg: shared constants for the time window hit grouper
// Default widths, window register width and reset, queue depth, tuser bits, func codes.
// ----------------------------------------------------------------------------
package twhg_pkg;

  localparam int TIME_BITS_DEF   = 48;
  localparam int ENERGY_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int WINDOW_BITS = 32;
  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 32'd1000;

  // tuser bit positions on the input side
  localparam int USER_FUNC_BIT = 0;
  localparam int USER_OK_BIT   = 1;
  localparam int USER_BITS     = 2;

  // func codes
  localparam logic FUNC_HIT   = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

endpackage
`default_nettype wire

// File: hdl/twhg_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twhg_front: input side of the grouper
// Takes input transfers, drops hits whose valid flag is clear, and pushes
// hits and flushes into the queue as {flush, energy, time}.
// ----------------------------------------------------------------------------
module twhg_front #(
  parameter int TIME_BITS   = twhg_pkg::TIME_BITS_DEF,
  parameter int ENERGY_BITS = twhg_pkg::ENERGY_BITS_DEF,
  parameter int DATA_W      = ((TIME_BITS + ENERGY_BITS + 7) / 8) * 8,
  parameter int ENT_W       = 1 + TIME_BITS + ENERGY_BITS
) (
  input  wire logic                           s_axis_tvalid,
  output      logic                           s_axis_tready,
  input  wire logic [DATA_W-1:0]              s_axis_tdata,
  input  wire logic [twhg_pkg::USER_BITS-1:0] s_axis_tuser,
  input  wire logic                           q_full_i,
  output      logic                           q_push_o,
  output      logic [ENT_W-1:0]               q_wdata_o
);
  import twhg_pkg::*;

  logic                   is_flush;
  logic                   hit_ok;
  logic [TIME_BITS-1:0]   hit_time;
  logic [ENERGY_BITS-1:0] hit_energy;

  assign is_flush   = (s_axis_tuser[USER_FUNC_BIT] == FUNC_FLUSH);
  assign hit_ok     = s_axis_tuser[USER_OK_BIT];
  assign hit_time   = s_axis_tdata[TIME_BITS-1:0];
  assign hit_energy = s_axis_tdata[TIME_BITS +: ENERGY_BITS];

  // an invalid hit is taken and dropped here, it never reaches the queue
  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i && (is_flush || hit_ok);
  assign q_wdata_o     = {is_flush, hit_energy, hit_time};

endmodule
`default_nettype wire

// File: hdl/twhg_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twhg_queue: small fifo between front and back
// Push and pop may happen in the same cycle; read side is first-word-through.
// ----------------------------------------------------------------------------
module twhg_queue #(
  parameter int WIDTH = 65,
  parameter int DEPTH = twhg_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      logic             valid_o,
  output      logic [WIDTH-1:0] rdata_o
);
  import twhg_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(DEPTH);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntMax);
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

// File: hdl/twhg_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twhg_back: group builder
// Holds the open group, compares each hit against the window, keeps the
// peak-energy hit and drives the registered result stage.
// ----------------------------------------------------------------------------
module twhg_back #(
  parameter int TIME_BITS   = twhg_pkg::TIME_BITS_DEF,
  parameter int ENERGY_BITS = twhg_pkg::ENERGY_BITS_DEF,
  parameter int ENT_W       = 1 + TIME_BITS + ENERGY_BITS
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [twhg_pkg::WINDOW_BITS-1:0] cfg_wdata_i,
  input  wire logic                             q_valid_i,
  input  wire logic [ENT_W-1:0]                 q_rdata_i,
  output      logic                             q_pop_o,
  output      logic                             out_valid_o,
  input  wire logic                             out_ready_i,
  output      logic [TIME_BITS-1:0]             out_time_o,
  output      logic [ENERGY_BITS-1:0]           out_energy_o
);
  import twhg_pkg::*;

  localparam int CmpW = (TIME_BITS > WINDOW_BITS) ? TIME_BITS : WINDOW_BITS;

  logic [WINDOW_BITS-1:0] window_q;
  logic                   open_q, open_d;
  logic [TIME_BITS-1:0]   start_q, start_d;
  logic [TIME_BITS-1:0]   peak_time_q, peak_time_d;
  logic [ENERGY_BITS-1:0] peak_energy_q, peak_energy_d;
  logic                   out_valid_q, out_valid_d;
  logic [TIME_BITS-1:0]   out_time_q;
  logic [ENERGY_BITS-1:0] out_energy_q;

  logic                   ent_flush;
  logic [TIME_BITS-1:0]   ent_time;
  logic [ENERGY_BITS-1:0] ent_energy;
  logic [TIME_BITS-1:0]   diff;
  logic                   joins;
  logic                   emit;

  assign ent_time   = q_rdata_i[TIME_BITS-1:0];
  assign ent_energy = q_rdata_i[TIME_BITS +: ENERGY_BITS];
  assign ent_flush  = q_rdata_i[ENT_W-1];

  // one entry per cycle whenever the result stage is free or draining
  assign q_pop_o = q_valid_i && (!out_valid_q || out_ready_i);

  // earlier than the reference always joins
  assign diff  = ent_time - start_q;
  assign joins = (ent_time < start_q) || (CmpW'(diff) < CmpW'(window_q));

  always_comb begin
    open_d        = open_q;
    start_d       = start_q;
    peak_time_d   = peak_time_q;
    peak_energy_d = peak_energy_q;
    emit          = 1'b0;
    if (q_pop_o) begin
      if (ent_flush) begin
        emit   = open_q;
        open_d = 1'b0;
      end else if (open_q && joins) begin
        if (ent_energy > peak_energy_q) begin
          peak_time_d   = ent_time;
          peak_energy_d = ent_energy;
        end
      end else begin
        emit          = open_q;
        open_d        = 1'b1;
        start_d       = ent_time;
        peak_time_d   = ent_time;
        peak_energy_d = ent_energy;
      end
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q      <= WINDOW_RESET;
      open_q        <= 1'b0;
      start_q       <= '0;
      peak_time_q   <= '0;
      peak_energy_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      open_q        <= open_d;
      start_q       <= start_d;
      peak_time_q   <= peak_time_d;
      peak_energy_q <= peak_energy_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_time_q   <= peak_time_q;
      out_energy_q <= peak_energy_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_time_o   = out_time_q;
  assign out_energy_o = out_energy_q;

endmodule
`default_nettype wire

// File: hdl/time_window_hit_grouper_top.sv
`timescale 1ns / 1ps
`default_nettype none
// path: a closing hit or flush is written into the queue, popped by the back end, and its
//   event is loaded into the result register that drives m_axis
// throughput: one input transfer per cycle while the queue has room; the back end
//   retires one queue entry per cycle while the result register is free or being taken
// reset: rst_ni is asynchronous, active low; clears the queue, the open group,
//   the result valid and loads the window with 1000 ticks
// ----------------------------------------------------------------------------
// time_window_hit_grouper_top: coincidence window event builder
// Groups a time-ordered hit stream into events, reporting the time and
// energy of the largest-energy hit of each group.
// ----------------------------------------------------------------------------
module time_window_hit_grouper_top #(
  parameter int TIME_BITS   = twhg_pkg::TIME_BITS_DEF,
  parameter int ENERGY_BITS = twhg_pkg::ENERGY_BITS_DEF,
  parameter int QUEUE_DEPTH = twhg_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // window register write, window_ticks
  input  wire logic                             cfg_we_i,
  input  wire logic [twhg_pkg::WINDOW_BITS-1:0] cfg_wdata_i,
  // input stream
  input  wire logic                             s_axis_tvalid,
  output      logic                             s_axis_tready,
  // hit_time, hit_energy, zero padding
  input  wire logic [((TIME_BITS + ENERGY_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // func, hit_ok
  input  wire logic [twhg_pkg::USER_BITS-1:0]   s_axis_tuser,
  // result stream
  output      logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // event_time, event_energy, zero padding
  output      logic [((TIME_BITS + ENERGY_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata
);
  import twhg_pkg::*;

  // packed payload width, rounded up to whole bytes
  localparam int DataW = ((TIME_BITS + ENERGY_BITS + 7) / 8) * 8;
  // queue entry: {flush, energy, time}
  localparam int EntW  = 1 + TIME_BITS + ENERGY_BITS;

  logic                   q_full;
  logic                   q_push;
  logic [EntW-1:0]        q_wdata;
  logic                   q_pop;
  logic                   q_valid;
  logic [EntW-1:0]        q_rdata;
  logic [TIME_BITS-1:0]   ev_time;
  logic [ENERGY_BITS-1:0] ev_energy;

  // front: takes every transfer while the queue has room, drops invalid hits
  twhg_front #(
    .TIME_BITS  (TIME_BITS),
    .ENERGY_BITS(ENERGY_BITS),
    .DATA_W     (DataW),
    .ENT_W      (EntW)
  ) u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_wdata_o    (q_wdata)
  );

  // queue: absorbs input while the result side is stalled
  twhg_queue #(
    .WIDTH(EntW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i(q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .rdata_o(q_rdata)
  );

  // back: group state, window compare, peak tracking and result register
  twhg_back #(
    .TIME_BITS  (TIME_BITS),
    .ENERGY_BITS(ENERGY_BITS),
    .ENT_W      (EntW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_rdata_i   (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_time_o  (ev_time),
    .out_energy_o(ev_energy)
  );

  // time in the low bits, energy above, zeros up to the byte boundary
  assign m_axis_tdata = DataW'({ev_energy, ev_time});

endmodule
`default_nettype wire

// File: hdl/twhg_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twhg_checker: port-level checks for the hit grouper
// Reset behavior of both streams and result stream stability.
// ----------------------------------------------------------------------------
module twhg_checker #(
  parameter int DATA_W = 64
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              s_axis_tvalid,
  input wire logic              s_axis_tready,
  input wire logic              m_axis_tvalid,
  input wire logic              m_axis_tready,
  input wire logic [DATA_W-1:0] m_axis_tdata
);

  // reset empties the result register
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid while in reset");

  // queue is empty right after reset, so input is taken at once
  assert property (@(posedge clk_i) $rose(rst_ni) |-> s_axis_tready)
    else $error("input not ready right after reset");

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result payload changed while stalled");

endmodule

bind time_window_hit_grouper_top twhg_checker #(
  .DATA_W(DataW)
) u_twhg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
`default_nettype wire
